FILE: design/pmsm_pkg.sv
// ----------------------------------------------------------------------------
// pmsm_pkg
// Shared types, codes and constants of the keyboard power-mode controller.
// ----------------------------------------------------------------------------
package pmsm_pkg;

    localparam int TIMEOUT_BITS = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_COUNT    = 7;
    localparam int CFG_IDX_W    = 3;

    typedef logic [TIMEOUT_BITS-1:0] t_timeout;
    typedef logic [CFG_W-1:0]        t_cfg_word;
    typedef t_cfg_word               t_cfg_bank [CFG_COUNT];

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_USB     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BAT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INACTIVE_USB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INACTIVE_BAT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_USB       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_BAT       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNPLUGGED      = 3'd6;

    localparam t_cfg_word CFG_RESET [CFG_COUNT] = '{
        16'd60, 16'd30, 16'd300, 16'd120, 16'd900, 16'd600, 16'd3600
    };

    // operations
    localparam logic [2:0] OP_TIMEOUT    = 3'd0;
    localparam logic [2:0] OP_USER       = 3'd1;
    localparam logic [2:0] OP_SYSTEM     = 3'd2;
    localparam logic [2:0] OP_DEMO_START = 3'd3;
    localparam logic [2:0] OP_DEMO_STOP  = 3'd4;
    localparam logic [2:0] OP_POWER_OFF  = 3'd5;
    localparam logic [2:0] OP_CONN       = 3'd6;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    // internal event codes; suspend only arises from a connection update
    localparam logic [2:0] EV_TIMEOUT    = 3'd0;
    localparam logic [2:0] EV_USER       = 3'd1;
    localparam logic [2:0] EV_SYSTEM     = 3'd2;
    localparam logic [2:0] EV_DEMO_START = 3'd3;
    localparam logic [2:0] EV_DEMO_STOP  = 3'd4;
    localparam logic [2:0] EV_POWER_OFF  = 3'd5;
    localparam logic [2:0] EV_SUSPEND    = 3'd7;

    // connection kinds
    localparam logic [2:0] CONN_NONE      = 3'd0;
    localparam logic [2:0] CONN_PC        = 3'd1;
    localparam logic [2:0] CONN_PC_SUSP   = 3'd2;
    localparam logic [2:0] CONN_SUPPLY    = 3'd3;
    localparam logic [2:0] CONN_UNPLUGGED = 3'd4;

    // notify kinds
    localparam logic [2:0] NOTE_NONE     = 3'd0;
    localparam logic [2:0] NOTE_ACTIVE   = 3'd1;
    localparam logic [2:0] NOTE_INACTIVE = 3'd2;
    localparam logic [2:0] NOTE_LONG     = 3'd3;
    localparam logic [2:0] NOTE_SLEEP    = 3'd4;
    localparam logic [2:0] NOTE_OFF      = 3'd5;
    localparam logic [2:0] NOTE_SUSPEND  = 3'd6;

    typedef enum logic [7:0] {
        MODE_ACTIVE   = 8'b0000_0001,
        MODE_INACTIVE = 8'b0000_0010,
        MODE_LONG     = 8'b0000_0100,
        MODE_SLEEP    = 8'b0000_1000,
        MODE_SLEEPU   = 8'b0001_0000,
        MODE_OFF      = 8'b0010_0000,
        MODE_DEMO     = 8'b0100_0000,
        MODE_SUSP     = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic [2:0]  power_state;
        logic        timeout_reloaded;
        logic [15:0] timeout_seconds;
        logic        timeout_infinite;
        logic        sleep_request;
        logic        shutdown_request;
        logic [2:0]  notify_kind;
    } t_result;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        c = 3'd0;
        unique case (m)
            MODE_ACTIVE:   c = 3'd0;
            MODE_INACTIVE: c = 3'd1;
            MODE_LONG:     c = 3'd2;
            MODE_SLEEP:    c = 3'd3;
            MODE_SLEEPU:   c = 3'd4;
            MODE_OFF:      c = 3'd5;
            MODE_DEMO:     c = 3'd6;
            MODE_SUSP:     c = 3'd7;
            default:       c = 3'd0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] notify_of(input t_mode m);
        logic [2:0] k;
        k = NOTE_NONE;
        unique case (m)
            MODE_ACTIVE:   k = NOTE_ACTIVE;
            MODE_INACTIVE: k = NOTE_INACTIVE;
            MODE_LONG:     k = NOTE_LONG;
            MODE_SLEEP:    k = NOTE_SLEEP;
            MODE_SLEEPU:   k = NOTE_SLEEP;
            MODE_OFF:      k = NOTE_OFF;
            MODE_DEMO:     k = NOTE_NONE;
            MODE_SUSP:     k = NOTE_SUSPEND;
            default:       k = NOTE_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: design/pmsm_in_if.sv
// ----------------------------------------------------------------------------
// pmsm_in_if
// Event channel: valid/ready handshake with operation and connection kind.
// ----------------------------------------------------------------------------
interface pmsm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [2:0] connection_kind;

    modport source (output valid, output operation, output connection_kind, input ready);
    modport sink   (input valid, input operation, input connection_kind, output ready);
endinterface

FILE: design/pmsm_out_if.sv
// ----------------------------------------------------------------------------
// pmsm_out_if
// Result channel: valid/ready handshake with the power-mode result word.
// ----------------------------------------------------------------------------
interface pmsm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  power_state;
    logic        timeout_reloaded;
    logic [15:0] timeout_seconds;
    logic        timeout_infinite;
    logic        sleep_request;
    logic        shutdown_request;
    logic [2:0]  notify_kind;

    modport source (
        output valid, output power_state, output timeout_reloaded,
        output timeout_seconds, output timeout_infinite, output sleep_request,
        output shutdown_request, output notify_kind, input ready
    );
    modport sink (
        input valid, input power_state, input timeout_reloaded,
        input timeout_seconds, input timeout_infinite, input sleep_request,
        input shutdown_request, input notify_kind, output ready
    );
endinterface

FILE: design/power_mode_state_machine_top.sv
// ----------------------------------------------------------------------------
// power_mode_state_machine_top
// Keyboard power-mode controller: event in, one result word out per event.
// ----------------------------------------------------------------------------
// Each accepted event yields exactly one result word: the event is held in the
// input register, then its result goes to the result register when not stalled.
// One event is taken every cycle as long as the result side keeps up; the
// limit is the single transition step between the two registers, which also
// updates the mode and timeout state. Timeout registers are to be written
// through the plain write port only while no event is in flight; the block
// does not enforce this. Indexes past the last register are ignored.
module power_mode_state_machine_top
    import pmsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pmsm_in_if.sink              i_in,
    pmsm_out_if.source           o_out
);

    t_cfg_bank  cfg;
    t_result    result;
    logic       advance;
    logic       fire;

    logic       r_in_valid;
    logic [2:0] r_operation;
    logic [2:0] r_connection_kind;
    logic       r_out_valid;
    t_result    r_result;

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_operation       <= i_in.operation;
            r_connection_kind <= i_in.connection_kind;
        end
        if (fire) begin
            r_result <= result;
        end
    end

    pmsm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pmsm_fsm u_fsm (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_operation       (r_operation),
        .i_connection_kind (r_connection_kind),
        .i_cfg             (cfg),
        .o_result          (result)
    );

    assign o_out.valid            = r_out_valid;
    assign o_out.power_state      = r_result.power_state;
    assign o_out.timeout_reloaded = r_result.timeout_reloaded;
    assign o_out.timeout_seconds  = r_result.timeout_seconds;
    assign o_out.timeout_infinite = r_result.timeout_infinite;
    assign o_out.sleep_request    = r_result.sleep_request;
    assign o_out.shutdown_request = r_result.shutdown_request;
    assign o_out.notify_kind      = r_result.notify_kind;

endmodule

FILE: design/pmsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// pmsm_cfg_regs
// Timeout configuration registers; writes past the last index are dropped.
// ----------------------------------------------------------------------------
module pmsm_cfg_regs
    import pmsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg_bank            o_cfg
);

    t_cfg_bank r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(CFG_COUNT))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/pmsm_fsm.sv
// ----------------------------------------------------------------------------
// pmsm_fsm
// Power-mode state, entry actions and notification tracking for one event.
// ----------------------------------------------------------------------------
module pmsm_fsm
    import pmsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [2:0] i_operation,
    input  logic [2:0] i_connection_kind,
    input  t_cfg_bank  i_cfg,
    output t_result    o_result
);

    t_mode      r_mode,       n_mode;
    logic [2:0] r_usb,        n_usb;
    t_timeout   r_timeout,    n_timeout;
    logic       r_infinite,   n_infinite;
    logic       r_last_valid, n_last_valid;
    logic [2:0] r_last_code,  n_last_code;

    logic       has_ev;
    logic [2:0] ev;
    logic       usb_on;
    logic       do_enter;
    logic       common;
    t_mode      target;
    logic       sleep_req;
    logic       shutdown_req;
    logic [2:0] notify;

    always_comb begin
        n_usb  = r_usb;
        has_ev = 1'b0;
        ev     = EV_TIMEOUT;
        case (i_operation) inside
            OP_CONN: begin
                // link kind is stored first; kinds 1 to 4 then act as events
                n_usb = i_connection_kind;
                case (i_connection_kind) inside
                    CONN_PC, CONN_SUPPLY, CONN_UNPLUGGED: begin
                        has_ev = 1'b1;
                        ev     = EV_USER;
                    end
                    CONN_PC_SUSP: begin
                        has_ev = 1'b1;
                        ev     = EV_SUSPEND;
                    end
                    default: ;
                endcase
            end
            OP_UNUSED: ;
            default: begin
                has_ev = 1'b1;
                ev     = i_operation;
            end
        endcase

        usb_on = (n_usb == CONN_PC) || (n_usb == CONN_PC_SUSP) || (n_usb == CONN_SUPPLY);

        do_enter = 1'b0;
        common   = 1'b0;
        target   = r_mode;
        unique case (r_mode)
            MODE_ACTIVE: begin
                if (ev == EV_TIMEOUT) begin
                    do_enter = 1'b1; target = MODE_INACTIVE;
                end else if (ev == EV_USER) begin
                    do_enter = 1'b1; target = MODE_ACTIVE;
                end else begin
                    common = 1'b1;
                end
            end
            MODE_INACTIVE: begin
                if (ev == EV_TIMEOUT) begin
                    do_enter = 1'b1; target = MODE_LONG;
                end else if (ev == EV_USER) begin
                    do_enter = 1'b1; target = MODE_ACTIVE;
                end else begin
                    common = 1'b1;
                end
            end
            MODE_LONG: begin
                if (ev == EV_TIMEOUT) begin
                    do_enter = 1'b1; target = usb_on ? MODE_SLEEP : MODE_SLEEPU;
                end else if (ev == EV_USER) begin
                    do_enter = 1'b1; target = MODE_ACTIVE;
                end else if (ev == EV_SYSTEM) begin
                    do_enter = 1'b1; target = MODE_LONG;
                end else begin
                    common = 1'b1;
                end
            end
            MODE_SLEEP: begin
                if (ev == EV_USER) begin
                    do_enter = 1'b1; target = MODE_ACTIVE;
                end else begin
                    common = 1'b1;
                end
            end
            MODE_SLEEPU: begin
                if (ev == EV_TIMEOUT) begin
                    do_enter = 1'b1; target = MODE_OFF;
                end else if (ev == EV_USER) begin
                    do_enter = 1'b1; target = MODE_ACTIVE;
                end else begin
                    common = 1'b1;
                end
            end
            MODE_OFF: ;
            MODE_DEMO: begin
                if (ev == EV_DEMO_STOP) begin
                    do_enter = 1'b1; target = MODE_ACTIVE;
                end else if (ev == EV_SUSPEND) begin
                    do_enter = 1'b1; target = MODE_SUSP;
                end else if (ev == EV_POWER_OFF) begin
                    do_enter = 1'b1; target = MODE_OFF;
                end
            end
            MODE_SUSP: begin
                if (ev == EV_USER) begin
                    do_enter = 1'b1; target = MODE_ACTIVE;
                end else if (ev == EV_POWER_OFF) begin
                    do_enter = 1'b1; target = MODE_OFF;
                end
            end
            default: ;
        endcase

        if (common) begin
            if (ev == EV_DEMO_START) begin
                do_enter = 1'b1; target = MODE_DEMO;
            end else if (ev == EV_SUSPEND) begin
                do_enter = 1'b1; target = MODE_SUSP;
            end else if (ev == EV_POWER_OFF) begin
                do_enter = 1'b1; target = MODE_OFF;
            end
        end
        do_enter = do_enter && has_ev;

        // entry actions
        n_mode       = r_mode;
        n_timeout    = r_timeout;
        n_infinite   = r_infinite;
        n_last_valid = r_last_valid;
        n_last_code  = r_last_code;
        sleep_req    = 1'b0;
        shutdown_req = 1'b0;
        notify       = NOTE_NONE;
        if (do_enter) begin
            n_mode = target;
            if (!r_last_valid || (r_last_code != mode_code(target))) begin
                notify       = notify_of(target);
                n_last_valid = 1'b1;
                n_last_code  = mode_code(target);
            end
            n_timeout  = '0;
            n_infinite = 1'b1;
            unique case (target)
                MODE_ACTIVE: begin
                    n_infinite = 1'b0;
                    n_timeout  = TIMEOUT_BITS'(usb_on ? i_cfg[REG_ACTIVE_USB]
                                                      : i_cfg[REG_ACTIVE_BAT]);
                end
                MODE_INACTIVE: begin
                    n_infinite = 1'b0;
                    n_timeout  = TIMEOUT_BITS'(usb_on ? i_cfg[REG_INACTIVE_USB]
                                                      : i_cfg[REG_INACTIVE_BAT]);
                end
                MODE_LONG: begin
                    n_infinite = 1'b0;
                    n_timeout  = TIMEOUT_BITS'(usb_on ? i_cfg[REG_LONG_USB]
                                                      : i_cfg[REG_LONG_BAT]);
                end
                MODE_SLEEP: sleep_req = 1'b1;
                MODE_SLEEPU: begin
                    sleep_req = 1'b1;
                    if (!usb_on) begin
                        n_infinite = 1'b0;
                        n_timeout  = TIMEOUT_BITS'(i_cfg[REG_UNPLUGGED]);
                    end
                end
                MODE_OFF: shutdown_req = 1'b1;
                default: ;
            endcase
        end

        o_result.power_state      = mode_code(n_mode);
        o_result.timeout_reloaded = do_enter;
        o_result.timeout_seconds  = 16'(n_timeout);
        o_result.timeout_infinite = n_infinite;
        o_result.sleep_request    = sleep_req;
        o_result.shutdown_request = shutdown_req;
        o_result.notify_kind      = notify;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_ACTIVE;
            r_usb        <= CONN_NONE;
            r_timeout    <= '0;
            r_infinite   <= 1'b1;
            r_last_valid <= 1'b0;
            r_last_code  <= '0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_usb        <= n_usb;
            r_timeout    <= n_timeout;
            r_infinite   <= n_infinite;
            r_last_valid <= n_last_valid;
            r_last_code  <= n_last_code;
        end
    end

endmodule

FILE: bench/power_mode_state_machine_top_test.sv
// ----------------------------------------------------------------------------
// power_mode_state_machine_top_test
// Self-checking bench for the keyboard power-mode controller. Events go in
// through the valid/ready event channel with random gaps. A model of the
// mode, USB link and timeout state in the bench computes the expected result
// word for every accepted event. Each result word is compared field by field
// against the oldest expected word while the result side stalls at random.
// The timeout registers are reloaded between phases with zeros, all ones,
// random and reset values. Off is a terminal mode, so it is entered only at
// the end of the run.
// ----------------------------------------------------------------------------
module power_mode_state_machine_top_test;
    import pmsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PM_ACTIVE, PM_INACTIVE, PM_LONG, PM_SLEEP,
        PM_SLEEPU, PM_OFF, PM_DEMO, PM_SUSP
    } pm_mode_e;

    localparam logic [3:0] NOTED_NONE = 4'd8;  // nothing notified yet
    localparam logic [3:0] GO_STAY    = 4'd8;  // event not handled
    localparam logic [3:0] GO_SELF    = 4'd9;  // rerun entry of current mode
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = CFG_IDX_W'(CFG_COUNT);
    localparam int RUN_LIMIT  = 400000;
    localparam int WAIT_MAX   = 13;
    localparam int PHASE_LEN  = 220;
    localparam int PRINT_MAX  = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    pmsm_in_if  in_if ();
    pmsm_out_if out_if ();

    power_mode_state_machine_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // bench copy of the controller state
    pm_mode_e   cur_mode;
    logic [2:0] usb_link;
    t_timeout   sel_timeout;
    logic       sel_infinite;
    logic [3:0] last_noted;
    t_cfg_bank  timeout_regs;

    t_result pending_words [$];
    int      mismatches  = 0;
    int      words_seen  = 0;
    int      cycle_count = 0;
    bit      calm        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // state model
    // ------------------------------------------------------------------
    function automatic logic usb_up();
        return usb_link == CONN_PC || usb_link == CONN_PC_SUSP || usb_link == CONN_SUPPLY;
    endfunction

    function automatic logic [2:0] note_for(pm_mode_e m);
        case (m)
            PM_ACTIVE:   return NOTE_ACTIVE;
            PM_INACTIVE: return NOTE_INACTIVE;
            PM_LONG:     return NOTE_LONG;
            PM_SLEEP,
            PM_SLEEPU:   return NOTE_SLEEP;
            PM_OFF:      return NOTE_OFF;
            PM_SUSP:     return NOTE_SUSPEND;
            default:     return NOTE_NONE;
        endcase
    endfunction

    function automatic void enter_mode(pm_mode_e m, inout t_result r);
        cur_mode = m;
        r.timeout_reloaded = 1'b1;
        if ({1'b0, m} != last_noted) begin
            r.notify_kind = note_for(m);
            last_noted = {1'b0, m};
        end
        sel_infinite = 1'b0;
        case (m)
            PM_ACTIVE:   sel_timeout = timeout_regs[usb_up() ? REG_ACTIVE_USB : REG_ACTIVE_BAT];
            PM_INACTIVE: sel_timeout = timeout_regs[usb_up() ? REG_INACTIVE_USB
                                                             : REG_INACTIVE_BAT];
            PM_LONG:     sel_timeout = timeout_regs[usb_up() ? REG_LONG_USB : REG_LONG_BAT];
            PM_SLEEP: begin
                sel_infinite = 1'b1;
                r.sleep_request = 1'b1;
            end
            PM_SLEEPU: begin
                sel_infinite = usb_up();
                sel_timeout = timeout_regs[REG_UNPLUGGED];
                r.sleep_request = 1'b1;
            end
            PM_OFF: begin
                sel_infinite = 1'b1;
                r.shutdown_request = 1'b1;
            end
            default: sel_infinite = 1'b1;
        endcase
        if (sel_infinite)
            sel_timeout = '0;
    endfunction

    function automatic logic [3:0] mode_after(logic [2:0] ev);
        case (cur_mode)
            PM_ACTIVE: begin
                if (ev == EV_TIMEOUT) return {1'b0, PM_INACTIVE};
                if (ev == EV_USER)    return GO_SELF;
            end
            PM_INACTIVE: begin
                if (ev == EV_TIMEOUT) return {1'b0, PM_LONG};
                if (ev == EV_USER)    return {1'b0, PM_ACTIVE};
            end
            PM_LONG: begin
                if (ev == EV_TIMEOUT) return {1'b0, usb_up() ? PM_SLEEP : PM_SLEEPU};
                if (ev == EV_USER)    return {1'b0, PM_ACTIVE};
                if (ev == EV_SYSTEM)  return GO_SELF;
            end
            PM_SLEEP: begin
                if (ev == EV_USER)    return {1'b0, PM_ACTIVE};
            end
            PM_SLEEPU: begin
                if (ev == EV_TIMEOUT) return {1'b0, PM_OFF};
                if (ev == EV_USER)    return {1'b0, PM_ACTIVE};
            end
            PM_OFF: return GO_STAY;
            PM_DEMO: begin
                if (ev == EV_DEMO_STOP) return {1'b0, PM_ACTIVE};
                if (ev == EV_SUSPEND)   return {1'b0, PM_SUSP};
                if (ev == EV_POWER_OFF) return {1'b0, PM_OFF};
                return GO_STAY;
            end
            default: begin
                if (ev == EV_USER)      return {1'b0, PM_ACTIVE};
                if (ev == EV_POWER_OFF) return {1'b0, PM_OFF};
                return GO_STAY;
            end
        endcase
        // shared by active, inactive, long inactive and both sleeps
        if (ev == EV_DEMO_START) return {1'b0, PM_DEMO};
        if (ev == EV_SUSPEND)    return {1'b0, PM_SUSP};
        if (ev == EV_POWER_OFF)  return {1'b0, PM_OFF};
        return GO_STAY;
    endfunction

    function automatic void apply_event(logic [2:0] ev, inout t_result r);
        logic [3:0] nxt;
        nxt = mode_after(ev);
        if (nxt == GO_SELF)
            enter_mode(cur_mode, r);
        else if (nxt != GO_STAY)
            enter_mode(pm_mode_e'(nxt[2:0]), r);
    endfunction

    function automatic t_result power_step(logic [2:0] op, logic [2:0] kind);
        t_result r;
        r = '0;
        if (op == OP_CONN) begin
            usb_link = kind;
            if (kind == CONN_PC || kind == CONN_SUPPLY || kind == CONN_UNPLUGGED)
                apply_event(EV_USER, r);
            else if (kind == CONN_PC_SUSP)
                apply_event(EV_SUSPEND, r);
        end else if (op != OP_UNUSED) begin
            // operation codes 0..5 double as event codes
            apply_event(op, r);
        end
        r.power_state      = cur_mode;
        r.timeout_seconds  = sel_timeout[15:0];
        r.timeout_infinite = sel_infinite;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------
    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, WAIT_MAX));
    endfunction

    task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("ERROR word %0d: %s got %0h expected %0h", words_seen, what, got, want);
    endtask

    task automatic check_power_word();
        t_result want;
        words_seen++;
        if (pending_words.size() == 0) begin
            flag_mismatch("word with nothing expected", 16'(out_if.power_state), 16'd0);
            return;
        end
        want = pending_words.pop_front();
        if (out_if.power_state !== want.power_state)
            flag_mismatch("power_state", 16'(out_if.power_state), 16'(want.power_state));
        if (out_if.timeout_reloaded !== want.timeout_reloaded)
            flag_mismatch("timeout_reloaded", 16'(out_if.timeout_reloaded),
                          16'(want.timeout_reloaded));
        if (out_if.timeout_seconds !== want.timeout_seconds)
            flag_mismatch("timeout_seconds", out_if.timeout_seconds, want.timeout_seconds);
        if (out_if.timeout_infinite !== want.timeout_infinite)
            flag_mismatch("timeout_infinite", 16'(out_if.timeout_infinite),
                          16'(want.timeout_infinite));
        if (out_if.sleep_request !== want.sleep_request)
            flag_mismatch("sleep_request", 16'(out_if.sleep_request), 16'(want.sleep_request));
        if (out_if.shutdown_request !== want.shutdown_request)
            flag_mismatch("shutdown_request", 16'(out_if.shutdown_request),
                          16'(want.shutdown_request));
        if (out_if.notify_kind !== want.notify_kind)
            flag_mismatch("notify_kind", 16'(out_if.notify_kind), 16'(want.notify_kind));
    endtask

    // result side: check every word, then hold ready low for a drawn stall
    initial begin
        int hold;
        hold = 0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                check_power_word();
                hold = draw_wait();
            end else if (hold > 0) begin
                hold--;
            end
            out_if.ready <= (hold == 0);
        end
    end

    task automatic send_event(logic [2:0] op, logic [2:0] kind);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.operation       <= op;
        in_if.connection_kind <= kind;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pending_words.push_back(power_step(op, kind));
    endtask

    // all results in: waits until every expected word is checked, leaving the two-stage pipe empty
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_timeouts(input t_cfg_bank bank, input bit stray);
        for (int i = 0; i < CFG_COUNT; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= bank[i];
            @(posedge i_clk);
            timeout_regs[i] = bank[i];
        end
        if (stray) begin
            // past the last register: must not land anywhere
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_PAST_END;
            i_cfg_data <= t_cfg_word'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [2:0] any_kind();
        return 3'($urandom_range(0, 7));
    endfunction

    task automatic random_events(int count);
        int w;
        logic [2:0] op;
        logic [2:0] kind;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            if ($urandom_range(0, 49) == 0)
                drain_results();
            w = $urandom_range(0, 99);
            if (w < 28)      op = OP_TIMEOUT;
            else if (w < 48) op = OP_USER;
            else if (w < 58) op = OP_SYSTEM;
            else if (w < 64) op = OP_DEMO_START;
            else if (w < 72) op = OP_DEMO_STOP;
            else if (w < 95) op = OP_CONN;
            else             op = OP_UNUSED;
            kind = any_kind();
            if (op == OP_CONN && $urandom_range(0, 3) != 0)
                kind = 3'($urandom_range(CONN_NONE, CONN_UNPLUGGED));
            // off is terminal: keep away from it until the last test
            if (op == OP_TIMEOUT && cur_mode == PM_SLEEPU)
                op = OP_USER;
            send_event(op, kind);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_battery_walk();
        send_event(OP_UNUSED, 3'd7);
        send_event(OP_USER, CONN_NONE);       // first re-entry notifies
        send_event(OP_USER, CONN_NONE);       // second one does not
        send_event(OP_SYSTEM, CONN_NONE);     // ignored in active
        send_event(OP_TIMEOUT, CONN_NONE);
        send_event(OP_TIMEOUT, CONN_NONE);
        send_event(OP_SYSTEM, CONN_NONE);     // long inactive re-entry
        send_event(OP_USER, CONN_NONE);
        send_event(OP_TIMEOUT, CONN_NONE);
        send_event(OP_TIMEOUT, CONN_NONE);
        send_event(OP_TIMEOUT, CONN_NONE);    // unplugged sleep
        send_event(OP_USER, CONN_NONE);
        send_event(OP_DEMO_START, CONN_NONE);
        send_event(OP_TIMEOUT, CONN_NONE);    // ignored in demo
        send_event(OP_DEMO_STOP, CONN_NONE);
    endtask

    task automatic test_usb_walk();
        send_event(OP_CONN, 3'd5);            // unknown kind: stored, no event
        send_event(OP_CONN, CONN_SUPPLY);
        send_event(OP_TIMEOUT, CONN_NONE);
        send_event(OP_TIMEOUT, CONN_NONE);
        send_event(OP_TIMEOUT, CONN_NONE);    // sleep with link up
        send_event(OP_TIMEOUT, CONN_NONE);
        send_event(OP_CONN, CONN_PC);
        send_event(OP_CONN, CONN_PC_SUSP);
        send_event(OP_USER, CONN_NONE);
        send_event(OP_DEMO_START, CONN_NONE);
        send_event(OP_CONN, CONN_PC_SUSP);    // demo to suspended
        send_event(OP_CONN, CONN_NONE);
        send_event(OP_CONN, CONN_UNPLUGGED);
    endtask

    task automatic test_register_settings();
        t_cfg_bank bank;
        for (int p = 0; p < 6; p++) begin
            drain_results();
            foreach (bank[i]) begin
                case (p)
                    0: bank[i] = '0;
                    1: bank[i] = '1;
                    3: bank[i] = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    5: bank[i] = CFG_RESET[i];
                    default: bank[i] = t_cfg_word'($urandom);
                endcase
            end
            load_timeouts(bank, p == 2);
            random_events(PHASE_LEN);
        end
    endtask

    task automatic test_power_off();
        drain_results();
        if ($urandom_range(0, 1) != 0) begin
            send_event(OP_POWER_OFF, any_kind());
        end else begin
            // reach unplugged sleep on battery, then let it time out
            send_event(OP_DEMO_STOP, any_kind());
            send_event(OP_CONN, CONN_UNPLUGGED);
            while (cur_mode != PM_SLEEPU)
                send_event(OP_TIMEOUT, any_kind());
            send_event(OP_TIMEOUT, any_kind());
        end
        // nothing leaves off
        for (int op = 0; op < 8; op++)
            send_event(3'(op), any_kind());
        send_event(OP_CONN, CONN_PC);
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= '0;
        i_cfg_data            <= '0;
        in_if.valid           <= 1'b0;
        in_if.operation       <= OP_TIMEOUT;
        in_if.connection_kind <= CONN_NONE;
        cur_mode     = PM_ACTIVE;
        usb_link     = CONN_NONE;
        sel_timeout  = '0;
        sel_infinite = 1'b1;
        last_noted   = NOTED_NONE;
        timeout_regs = CFG_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_battery_walk();
        test_usb_walk();
        test_register_settings();
        test_power_off();
        drain_results();
        repeat (4) @(posedge i_clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
